### sv/swa_pkg.sv
// shared constants, divider stage type and window helper for the sliding window average
`timescale 1ns / 1ps

package swa_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_BITS    = $clog2(WINDOW_MAX);
  localparam int WIN_BITS    = PTR_BITS + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
  localparam int DIV_STAGES  = SUM_BITS;

  // one slot of the divider chain: control, carried result and partial quotient
  typedef struct packed {
    logic                       valid;
    logic                       neg;
    logic signed [SUM_BITS-1:0] sum;
    logic [WIN_BITS-1:0]        div;
    logic [WIN_BITS-1:0]        rem;
    logic [SUM_BITS-1:0]        dq;
  } div_stage_t;

  // zero acts as one, anything above the line length is clipped
  function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] raw);
    logic [WIN_BITS-1:0] w;
    w = raw;
    if (raw == '0) begin
      w = WIN_BITS'(1);
    end else if (raw > WIN_BITS'(WINDOW_MAX)) begin
      w = WIN_BITS'(WINDOW_MAX);
    end
    return w;
  endfunction

endpackage

### sv/sliding_window_average.sv
// top level of the sliding window average: delay line, running sum, divider chain
`timescale 1ns / 1ps

// Moving average over the last window_size samples (1..64, zero acts as one,
// larger values act as 64). Each item carries a signed 16-bit sample and a
// restart flag; a restart clears the fill count and running sum before the sample
// is taken. No result comes out until window_size samples of the current sequence
// have arrived; after that every item gives one result with the window sum and the
// sum divided by the window size, truncated toward zero. Writing window_size also
// starts a new sequence; write it only while the block is idle. The block takes one
// item per cycle while in_stall is low: the delay line and running sum are updated
// once per item, and the division runs down a chain of 22 one-bit cells. Each
// result passes the front register, loaded at the accepting edge, then the 22
// divider cells, then the output register. in_stall is high exactly while a
// result waits stalled at the output; the whole pipe freezes then. No memory
// clearing after reset.

module sliding_window_average import swa_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // sample items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          restart,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic signed [SUM_BITS-1:0]    window_sum,
  // window size register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [WIN_BITS-1:0]           window_size
);

  // pipeline advance: everything moves unless a result is stuck at the output
  logic en;
  logic accept;
  logic cfg_wr;

  // front end state
  logic [WIN_BITS-1:0]        wsel;
  logic [WIN_BITS-1:0]        fill;
  logic signed [SUM_BITS-1:0] run_sum;
  logic [PTR_BITS-1:0]        w_m1;

  // front end next values
  logic [WIN_BITS-1:0]        fill_base;
  logic signed [SUM_BITS-1:0] sum_base;
  logic signed [SUM_BITS-1:0] sub_ext;
  logic signed [SUM_BITS-1:0] sample_ext;
  logic signed [SUM_BITS-1:0] sum_next;
  logic [WIN_BITS-1:0]        fill_next;
  logic                       has_result;

  // delay line: tap[0] holds the sample that entered window-size items ago
  logic signed [SAMPLE_BITS-1:0] tap [WINDOW_MAX];

  // divider chain
  div_stage_t fe;
  div_stage_t div_in;
  div_stage_t stg [DIV_STAGES+1];
  div_stage_t last;

  logic [SUM_BITS-1:0] avg_full;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign w_m1 = PTR_BITS'(wsel - WIN_BITS'(1));

  // running sum update: drop the oldest once the window is full, add the new one
  always_comb begin
    fill_base  = restart ? '0 : fill;
    sum_base   = restart ? '0 : run_sum;
    sub_ext    = (fill_base >= wsel) ? {{PTR_BITS{tap[0][SAMPLE_BITS-1]}}, tap[0]} : '0;
    sample_ext = {{PTR_BITS{sample[SAMPLE_BITS-1]}}, sample};
    sum_next   = sum_base - sub_ext + sample_ext;
    fill_next  = (fill_base < wsel) ? fill_base + WIN_BITS'(1) : fill_base;
    has_result = (fill_next == wsel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsel     <= WIN_BITS'(1);
      fill     <= '0;
      run_sum  <= '0;
      fe.valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        // new size starts a new sequence
        wsel    <= eff_window(window_size);
        fill    <= '0;
        run_sum <= '0;
      end else if (accept) begin
        fill    <= fill_next;
        run_sum <= sum_next;
      end
      if (en) begin
        fe.valid <= accept && has_result;
        fe.neg   <= sum_next[SUM_BITS-1];
        fe.sum   <= sum_next;
        fe.div   <= wsel;
        fe.rem   <= '0;
        fe.dq    <= '0;
      end
    end
  end

  // new sample enters at cell window-1 and walks down toward cell 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_tap
    logic signed [SAMPLE_BITS-1:0] upper;
    if (i == WINDOW_MAX - 1) begin : g_top
      assign upper = sample;
    end else begin : g_mid
      assign upper = tap[i+1];
    end
    swa_tap_cell u_tap (
      .clk       (clk),
      .shift     (accept),
      .load_new  (w_m1 == PTR_BITS'(i)),
      .new_sample(sample),
      .upper     (upper),
      .q         (tap[i])
    );
  end

  // divider works on the magnitude; sign is restored at the end
  always_comb begin
    div_in     = fe;
    div_in.dq  = fe.neg ? SUM_BITS'(-fe.sum) : SUM_BITS'(fe.sum);
    div_in.rem = '0;
  end

  assign stg[0] = div_in;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    swa_div_cell u_div (
      .clk(clk),
      .rst(rst),
      .en (en),
      .d  (stg[k]),
      .q  (stg[k+1])
    );
  end

  assign last     = stg[DIV_STAGES];
  assign avg_full = last.neg ? (~last.dq + SUM_BITS'(1)) : last.dq;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid  <= last.valid;
      average    <= avg_full[SAMPLE_BITS-1:0];
      window_sum <= last.sum;
    end
  end

endmodule

### sv/swa_tap_cell.sv
// one cell of the variable-length sample delay line
`timescale 1ns / 1ps

module swa_tap_cell import swa_pkg::*; (
  input  logic                          clk,
  input  logic                          shift,
  input  logic                          load_new,
  input  logic signed [SAMPLE_BITS-1:0] new_sample,
  input  logic signed [SAMPLE_BITS-1:0] upper,
  output logic signed [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= load_new ? new_sample : upper;
    end
  end

endmodule

### sv/swa_div_cell.sv
// one restoring-division cell: settles one quotient bit per item passing through
`timescale 1ns / 1ps

module swa_div_cell import swa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t d,
  output div_stage_t q
);

  logic [WIN_BITS:0] trial;
  logic [WIN_BITS:0] diff;
  logic              fits;
  div_stage_t        nxt;

  always_comb begin
    trial    = {d.rem, d.dq[SUM_BITS-1]};
    diff     = trial - {1'b0, d.div};
    fits     = (trial >= {1'b0, d.div});
    nxt      = d;
    nxt.rem  = fits ? diff[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
    nxt.dq   = {d.dq[SUM_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

### sv/swa_checker.sv
// port-level checker for the sliding window average and its bind
`timescale 1ns / 1ps

module swa_checker import swa_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] average,
  input logic signed [SUM_BITS-1:0]    window_sum,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // input side stalls only while a result is held at the output
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow a held result");

  // a stalled result holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average) && $stable(window_sum))
    else $error("stalled result changed");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // the register port never refuses a write
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("window size write refused");

endmodule

bind sliding_window_average swa_checker u_swa_checker (.*);
